>>> rtl/npe_pkg.sv
// Shared types and constants for the nearest-point Euclidean search block.
`default_nettype none
package npe_pkg;

    localparam int COORD_W = 24;   // signed Q12.12 coordinate
    localparam int MAG_W   = 24;   // magnitude of a coordinate difference
    localparam int SQ_W    = 48;   // square of one magnitude
    localparam int SUM_W   = 50;   // sum of three squares
    localparam int ROOT_W  = 25;   // floor root of the sum
    localparam int DIST_W  = 26;   // distance port width
    localparam int IDX_W   = 10;   // nearest index port width
    localparam int DATA_W  = 32;   // configuration data width
    localparam int ADDR_W  = 4;    // configuration address width

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_LAT = 2'd0;
    localparam logic [1:0] REG_LON = 2'd1;
    localparam logic [1:0] REG_ALT = 2'd2;

    // One queued item: exact squared sum and the end-of-set mark
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } npe_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DONE
    } npe_back_state_t;

endpackage
`default_nettype wire

>>> rtl/npe_front.sv
// Front end: accepts points, forms squared differences and their sum.
`default_nettype none
module npe_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [npe_pkg::COORD_W-1:0] pt_lat,
    input  wire logic signed [npe_pkg::COORD_W-1:0] pt_lon,
    input  wire logic signed [npe_pkg::COORD_W-1:0] pt_alt,
    input  wire logic                              set_end,
    input  wire logic signed [npe_pkg::COORD_W-1:0] ref_lat,
    input  wire logic signed [npe_pkg::COORD_W-1:0] ref_lon,
    input  wire logic signed [npe_pkg::COORD_W-1:0] ref_alt,
    input  wire logic                              credit_return,
    output logic                                   q_push,
    output npe_pkg::npe_item_t                     q_item
);

    localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [npe_pkg::MAG_W-1:0] abs_diff(
        input logic [npe_pkg::COORD_W-1:0] a,
        input logic [npe_pkg::COORD_W-1:0] b
    );
        logic signed [npe_pkg::COORD_W:0] d;
        logic        [npe_pkg::COORD_W:0] m;
        begin
            d = $signed({a[npe_pkg::COORD_W-1], a}) - $signed({b[npe_pkg::COORD_W-1], b});
            m = d[npe_pkg::COORD_W] ? (~d + 1'b1) : d;
            abs_diff = m[npe_pkg::MAG_W-1:0];
        end
    endfunction

    logic [CRED_W-1:0]         credit_reg, credit_next;
    logic                      v1_reg, v2_reg, v3_reg;
    logic [npe_pkg::MAG_W-1:0] m_lat_reg, m_lon_reg, m_alt_reg;
    logic [npe_pkg::SQ_W-1:0]  s_lat_reg, s_lon_reg, s_alt_reg;
    logic [npe_pkg::SUM_W-1:0] sum_reg;
    logic                      last1_reg, last2_reg, last3_reg;
    logic                      accept;

    assign full   = (credit_reg == '0);
    assign accept = push && !full;

    // A credit is spent on accept and returned when the back end pops an item from the queue
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !credit_return)
        begin
            credit_next = credit_reg - 1'b1;
        end
        else if (!accept && credit_return)
        begin
            credit_next = credit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= CRED_W'(QUEUE_DEPTH);
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_lat_reg <= abs_diff(ref_lat, pt_lat);
        m_lon_reg <= abs_diff(ref_lon, pt_lon);
        m_alt_reg <= abs_diff(ref_alt, pt_alt);
        last1_reg <= set_end;
        s_lat_reg <= m_lat_reg * m_lat_reg;
        s_lon_reg <= m_lon_reg * m_lon_reg;
        s_alt_reg <= m_alt_reg * m_alt_reg;
        last2_reg <= last1_reg;
        sum_reg   <= npe_pkg::SUM_W'(s_lat_reg) + npe_pkg::SUM_W'(s_lon_reg)
                   + npe_pkg::SUM_W'(s_alt_reg);
        last3_reg <= last2_reg;
    end

    assign q_push      = v3_reg;
    assign q_item.sum  = sum_reg;
    assign q_item.last = last3_reg;

endmodule
`default_nettype wire

>>> rtl/npe_queue.sv
// Short queue of squared sums between the front and back ends.
`default_nettype none
module npe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire npe_pkg::npe_item_t push_item,
    input  wire logic               pop,
    output logic                    empty,
    output npe_pkg::npe_item_t      head_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    npe_pkg::npe_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != CNT_W'(DEPTH))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on write");
`endif

endmodule
`default_nettype wire

>>> rtl/npe_back.sv
// Back end: iterative floor root, running nearest tracking, result register.
`default_nettype none
module npe_back #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire npe_pkg::npe_item_t            q_item,
    output logic                               q_pop,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [npe_pkg::DIST_W-1:0]         point_distance,
    output logic [npe_pkg::IDX_W-1:0]          nearest_index,
    output logic [npe_pkg::DIST_W-1:0]         nearest_distance,
    output logic                               set_done
);

    localparam int POS_W = $clog2(MAX_POINTS);
    localparam int SW    = npe_pkg::SUM_W;
    localparam int RW    = npe_pkg::ROOT_W;
    localparam logic [SW-1:0] ROOT_START = SW'(1) << (SW - 2);

    npe_pkg::npe_back_state_t state_reg, state_next;

    logic [SW-1:0]    rem_reg, rem_next;
    logic [SW-1:0]    res_reg, res_next;
    logic [SW-1:0]    bit_reg, bit_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic             last_reg, last_next;
    logic [SW:0]      trial;

    logic [SW-1:0]    best_sum_reg, best_sum_next;
    logic [POS_W-1:0] best_pos_reg, best_pos_next;
    logic [RW-1:0]    best_root_reg, best_root_next;
    logic [POS_W-1:0] seen_reg, seen_next;

    logic             out_valid_reg, out_valid_next;
    logic [RW-1:0]    pd_reg, nd_reg;
    logic [POS_W-1:0] ni_reg;
    logic             done_reg;
    logic             load_out;
    logic             better;
    logic [RW-1:0]    root;
    logic [npe_pkg::IDX_W+POS_W-1:0] idx_wide;

    assign root   = res_reg[RW-1:0];
    assign better = (seen_reg == '0) || (sum_reg < best_sum_reg);
    assign trial  = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        best_sum_next  = best_sum_reg;
        best_pos_next  = best_pos_reg;
        best_root_next = best_root_reg;
        seen_next      = seen_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            npe_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    rem_next   = q_item.sum;
                    sum_next   = q_item.sum;
                    last_next  = q_item.last;
                    res_next   = '0;
                    bit_next   = ROOT_START;
                    state_next = npe_pkg::ST_ROOT;
                end
            end
            npe_pkg::ST_ROOT:
            begin
                // one root bit per cycle
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next = rem_reg - trial[SW-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = npe_pkg::ST_DONE;
                end
            end
            npe_pkg::ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = npe_pkg::ST_IDLE;
                    if (last_reg)
                    begin
                        best_sum_next  = '0;
                        best_pos_next  = '0;
                        best_root_next = '0;
                        seen_next      = '0;
                    end
                    else
                    begin
                        if (better)
                        begin
                            best_sum_next  = sum_reg;
                            best_pos_next  = seen_reg;
                            best_root_next = root;
                        end
                        if (seen_reg != POS_W'(MAX_POINTS - 1))
                        begin
                            seen_next = seen_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = npe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            best_sum_reg  <= '0;
            best_pos_reg  <= '0;
            best_root_reg <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            best_sum_reg  <= best_sum_next;
            best_pos_reg  <= best_pos_next;
            best_root_reg <= best_root_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        sum_reg  <= sum_next;
        last_reg <= last_next;
        if (load_out)
        begin
            pd_reg   <= root;
            ni_reg   <= better ? seen_reg : best_pos_reg;
            nd_reg   <= better ? root : best_root_reg;
            done_reg <= last_reg;
        end
    end

    assign idx_wide         = {{npe_pkg::IDX_W{1'b0}}, ni_reg};
    assign empty            = !out_valid_reg;
    assign point_distance   = npe_pkg::DIST_W'(pd_reg);
    assign nearest_index    = idx_wide[npe_pkg::IDX_W-1:0];
    assign nearest_distance = npe_pkg::DIST_W'(nd_reg);
    assign set_done         = done_reg;

`ifndef SYNTH
    a_pop_starts_root: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == npe_pkg::ST_ROOT)
        else $error("queue read did not start a root run");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || pop)
        else $error("waiting result overwritten");
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        best_pos_reg <= seen_reg)
        else $error("nearest position ahead of points seen");
`endif

endmodule
`default_nettype wire

>>> rtl/nearest_point_euclidean_search.sv
// Top level of the nearest-point Euclidean search: registers, front, queue, back.
//
//  Channel   Signals                               Beat taken when
//  --------  ------------------------------------  -----------------------------
//  config    psel penable pwrite paddr pwdata      psel & penable & pwrite
//            prdata pready                         (pready tied high)
//  points    push full pt_lat pt_lon pt_alt        push & !full
//            set_end
//  results   empty pop point_distance              pop & !empty
//            nearest_index nearest_distance set_done
//
// Each point passes ST_IDLE (pulled from the queue), ST_ROOT (bit-serial floor root,
// one result bit per cycle) and ST_DONE (committed once the result register is free).
// That root loop sets the sustained rate; the front registers magnitudes, squares, sum.
// rst_n clears the reference registers, the tracking state, queue and credits.
// full rises when the queue and the front pipeline hold QUEUE_DEPTH points;
// a result waits in its register while the back end already works on the next.
`default_nettype none
module nearest_point_euclidean_search #(
    parameter int MAX_POINTS  = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [npe_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [npe_pkg::DATA_W-1:0]          pwdata,
    output logic [npe_pkg::DATA_W-1:0]               prdata,
    output logic                                     pready,
    // point input
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [npe_pkg::COORD_W-1:0]  pt_lat,
    input  wire logic signed [npe_pkg::COORD_W-1:0]  pt_lon,
    input  wire logic signed [npe_pkg::COORD_W-1:0]  pt_alt,
    input  wire logic                                set_end,
    // result output
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [npe_pkg::DIST_W-1:0]               point_distance,
    output logic [npe_pkg::IDX_W-1:0]                nearest_index,
    output logic [npe_pkg::DIST_W-1:0]               nearest_distance,
    output logic                                     set_done
);

    logic signed [npe_pkg::COORD_W-1:0] ref_lat_reg, ref_lon_reg, ref_alt_reg;
    logic [1:0]                         reg_idx;
    logic                               cfg_write;
    logic                               q_push, q_pop, q_empty;
    npe_pkg::npe_item_t                 q_in_item, q_head_item;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Reference point registers; a write to an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
            ref_alt_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                npe_pkg::REG_LAT: ref_lat_reg <= pwdata[npe_pkg::COORD_W-1:0];
                npe_pkg::REG_LON: ref_lon_reg <= pwdata[npe_pkg::COORD_W-1:0];
                npe_pkg::REG_ALT: ref_alt_reg <= pwdata[npe_pkg::COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back sign-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            npe_pkg::REG_LAT: prdata = npe_pkg::DATA_W'(ref_lat_reg);
            npe_pkg::REG_LON: prdata = npe_pkg::DATA_W'(ref_lon_reg);
            npe_pkg::REG_ALT: prdata = npe_pkg::DATA_W'(ref_alt_reg);
            default:          prdata = '0;
        endcase
    end

    npe_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pt_lat        (pt_lat),
        .pt_lon        (pt_lon),
        .pt_alt        (pt_alt),
        .set_end       (set_end),
        .ref_lat       (ref_lat_reg),
        .ref_lon       (ref_lon_reg),
        .ref_alt       (ref_alt_reg),
        .credit_return (q_pop),
        .q_push        (q_push),
        .q_item        (q_in_item)
    );

    npe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (q_head_item)
    );

    npe_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_item           (q_head_item),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .point_distance   (point_distance),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance),
        .set_done         (set_done)
    );

endmodule
`default_nettype wire
